/* design/tilt_angle_from_reference_macros.svh */
// Assertion macros for the tilt angle block.
// Used by files that assert; expects clk_i and rst_ni in scope.
`ifndef TILT_ANGLE_FROM_REFERENCE_MACROS_SVH
`define TILT_ANGLE_FROM_REFERENCE_MACROS_SVH

// Clocked check, off while in reset
`define TAFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication
`define TAFR_ASSERT_IMP(lbl, ante, cons, msg) \
  `TAFR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* design/tafr_pkg.sv */
// Shared constants, types and arctangent table for the tilt angle pipeline.
// No dependencies.
package tafr_pkg;

  localparam int unsigned DW              = 16;  // sample and register width
  localparam int unsigned PW              = 2 * DW + 1;  // dot/cross product width
  localparam int unsigned PRE_SHIFT       = 24;  // fixed-point prescale
  localparam int unsigned CW              = 60;  // CORDIC vector width
  localparam int unsigned ZW              = 32;  // angle accumulator width
  localparam int unsigned AW              = 15;  // output angle width
  localparam int unsigned TW              = 17;  // rounded angle before wrap
  localparam int unsigned TABLE_LEN       = 24;
  localparam int unsigned ANGLE_STEPS_DEF = 16;

  localparam logic signed [ZW-1:0] DEG180     = 32'sd754974720;
  localparam logic signed [ZW-1:0] DEG360     = 32'sd1509949440;
  localparam logic [TW-1:0]        ANGLE_WRAP = 17'd23040;
  localparam logic [ZW:0]          ROUND_HALF = 33'd32768;

  localparam logic [DW-1:0] REF_X_RESET = 16'd32767;
  localparam logic [DW-1:0] REF_Y_RESET = 16'd0;

  typedef enum logic [0:0] {
    REG_REF_X = 1'b0,
    REG_REF_Y = 1'b1
  } cfg_reg_e;

  // One word in flight through the rotation stages
  typedef struct packed {
    logic                 zero;
    logic signed [CW-1:0] re;
    logic signed [CW-1:0] im;
    logic signed [ZW-1:0] z;
  } rot_t;

  // atan(2^-i) in degrees, scaled by 2^22
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 32'sd188743680;
      1:  v = 32'sd111421900;
      2:  v = 32'sd58872272;
      3:  v = 32'sd29884485;
      4:  v = 32'sd15000234;
      5:  v = 32'sd7507429;
      6:  v = 32'sd3754631;
      7:  v = 32'sd1877430;
      8:  v = 32'sd938729;
      9:  v = 32'sd469366;
      10: v = 32'sd234683;
      11: v = 32'sd117342;
      12: v = 32'sd58671;
      13: v = 32'sd29335;
      14: v = 32'sd14668;
      15: v = 32'sd7334;
      16: v = 32'sd3667;
      17: v = 32'sd1833;
      18: v = 32'sd917;
      19: v = 32'sd458;
      20: v = 32'sd229;
      21: v = 32'sd115;
      22: v = 32'sd57;
      23: v = 32'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/tilt_angle_from_reference.sv */
// Tilt angle of a two-axis accelerometer sample relative to a reference vector.
// Input channel: in_valid_i / in_stall_o with sample_x_i, sample_y_i (signed).
// Output channel: out_valid_o / out_stall_i with angle_o (1/64 degree, 0..23039)
// and valid_res_o (low when sample or reference is the zero vector, angle 0).
// A word moves on a channel at a clock edge with valid high and stall low.
// Reference registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must write them only while the pipeline is empty, which the block
// does not enforce. Reset loads reference (32767, 0).
// Stages: 3 front, ANGLE_STEPS CORDIC (16 by default, capped at 24), 2 back.
// Throughput: one word per cycle; every stage is a register with its own valid
// bit, so the pipeline takes a new word each cycle the output is not stalled.
// When out_stall_i is held, words pile up into empty stages; in_stall_o rises
// only once every stage holds a word. Nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline comes out of reset empty.
// Depends on tafr_pkg, tafr_front, tafr_rot_stage, tafr_finish and the macros header.
`include "tilt_angle_from_reference_macros.svh"

module tilt_angle_from_reference import tafr_pkg::*; #(
  parameter int unsigned ANGLE_STEPS = ANGLE_STEPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [DW-1:0]        cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [DW-1:0] sample_x_i,
  input  logic signed [DW-1:0] sample_y_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [AW-1:0]        angle_o,
  output logic                 valid_res_o
);

  localparam int unsigned NSTEPS = (ANGLE_STEPS > TABLE_LEN) ? TABLE_LEN : ANGLE_STEPS;

  logic [DW-1:0] ref_x_q, ref_y_q;
  logic          front_ready;
  logic          rot_valid [NSTEPS+1];
  logic          rot_ready [NSTEPS+1];
  rot_t          rot_data  [NSTEPS+1];

  // reference registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q <= REF_X_RESET;
      ref_y_q <= REF_Y_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_REF_X: ref_x_q <= cfg_data_i;
        REG_REF_Y: ref_y_q <= cfg_data_i;
        default:   ref_x_q <= ref_x_q;
      endcase
    end
  end

  assign in_stall_o = !front_ready;

  tafr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (front_ready),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .ref_x_i    ($signed(ref_x_q)),
    .ref_y_i    ($signed(ref_y_q)),
    .valid_o    (rot_valid[0]),
    .ready_i    (rot_ready[0]),
    .data_o     (rot_data[0])
  );

  // CORDIC iterations, one register stage each
  for (genvar g = 0; g < NSTEPS; g++) begin : g_rot
    tafr_rot_stage #(
      .STEP (g)
    ) u_rot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rot_valid[g]),
      .ready_o (rot_ready[g]),
      .data_i  (rot_data[g]),
      .valid_o (rot_valid[g+1]),
      .ready_i (rot_ready[g+1]),
      .data_o  (rot_data[g+1])
    );
  end

  tafr_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (rot_valid[NSTEPS]),
    .ready_o     (rot_ready[NSTEPS]),
    .data_i      (rot_data[NSTEPS]),
    .valid_o     (out_valid_o),
    .ready_i     (!out_stall_i),
    .angle_o     (angle_o),
    .valid_res_o (valid_res_o)
  );

  // input backs up only when every stage is full and the output is held
  `TAFR_ASSERT_IMP(a_stall_needs_full, in_stall_o, out_valid_o && out_stall_i,
    "input stalled while output is not blocked")
  // delivered angle stays below one full turn
  `TAFR_ASSERT_IMP(a_angle_range, out_valid_o, angle_o < 15'd23040,
    "angle out of range")
  // degenerate vectors report angle zero
  `TAFR_ASSERT_IMP(a_zero_angle, out_valid_o && !valid_res_o, angle_o == '0,
    "nonzero angle on degenerate vector")

endmodule

/* design/tafr_front.sv */
// Front end: products, dot/cross sums, half-plane fold and prescale (3 stages).
// Depends on tafr_pkg.
module tafr_front import tafr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [DW-1:0] sample_x_i,
  input  logic signed [DW-1:0] sample_y_i,
  input  logic signed [DW-1:0] ref_x_i,
  input  logic signed [DW-1:0] ref_y_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rot_t                 data_o
);

  logic                   a_valid_q, b_valid_q, c_valid_q;
  logic                   a_ready, b_ready, c_ready;
  logic                   a_zero_q, b_zero_q;
  logic signed [2*DW-1:0] a_xrx_q, a_yry_q, a_yrx_q, a_xry_q;
  logic signed [2*DW-1:0] xrx_d, yry_d, yrx_d, xry_d;
  logic                   zero_d;
  logic signed [PW-1:0]   b_re_q, b_im_q, re_d, im_d;
  logic signed [CW-1:0]   re_ext, im_ext;
  rot_t                   c_d, c_q;

  // stage readiness: a stage takes a word when empty or draining
  assign a_ready = !a_valid_q || b_ready;
  assign b_ready = !b_valid_q || c_ready;
  assign c_ready = !c_valid_q || ready_i;
  assign ready_o = a_ready;

  // stage A: four products and the degenerate-vector flag
  assign xrx_d  = sample_x_i * ref_x_i;
  assign yry_d  = sample_y_i * ref_y_i;
  assign yrx_d  = sample_y_i * ref_x_i;
  assign xry_d  = sample_x_i * ref_y_i;
  assign zero_d = ((sample_x_i == '0) && (sample_y_i == '0)) ||
                  ((ref_x_i == '0) && (ref_y_i == '0));

  // stage B: dot product (re) and cross product (im)
  assign re_d = {a_xrx_q[2*DW-1], a_xrx_q} + {a_yry_q[2*DW-1], a_yry_q};
  assign im_d = {a_yrx_q[2*DW-1], a_yrx_q} - {a_xry_q[2*DW-1], a_xry_q};

  // stage C: prescale, fold left half-plane onto right with 180 deg offset
  assign re_ext = {{(CW-PW-PRE_SHIFT){b_re_q[PW-1]}}, b_re_q, {PRE_SHIFT{1'b0}}};
  assign im_ext = {{(CW-PW-PRE_SHIFT){b_im_q[PW-1]}}, b_im_q, {PRE_SHIFT{1'b0}}};

  always_comb begin
    c_d.zero = b_zero_q;
    if (b_re_q[PW-1]) begin
      c_d.re = -re_ext;
      c_d.im = -im_ext;
      c_d.z  = DEG180;
    end else begin
      c_d.re = re_ext;
      c_d.im = im_ext;
      c_d.z  = '0;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_xrx_q  <= xrx_d;
      a_yry_q  <= yry_d;
      a_yrx_q  <= yrx_d;
      a_xry_q  <= xry_d;
      a_zero_q <= zero_d;
    end
    if (b_ready && a_valid_q) begin
      b_re_q   <= re_d;
      b_im_q   <= im_d;
      b_zero_q <= a_zero_q;
    end
    if (c_ready && b_valid_q) begin
      c_q <= c_d;
    end
  end

  assign valid_o = c_valid_q;
  assign data_o  = c_q;

endmodule

/* design/tafr_rot_stage.sv */
// One vectoring CORDIC iteration, registered.
// Depends on tafr_pkg.
module tafr_rot_stage import tafr_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  rot_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output rot_t data_o
);

  logic                 valid_q;
  rot_t                 data_q, data_d;
  logic signed [CW-1:0] re_s, im_s, dre, dim;
  logic signed [ZW-1:0] atan_c;

  assign ready_o = !valid_q || ready_i;

  // arithmetic shifts by the iteration index
  assign re_s   = data_i.re;
  assign im_s   = data_i.im;
  assign dre    = im_s >>> STEP;
  assign dim    = re_s >>> STEP;
  assign atan_c = atan_entry(STEP);

  // rotate toward the x axis, steering on the sign of im
  always_comb begin
    data_d.zero = data_i.zero;
    if (!im_s[CW-1]) begin
      data_d.re = re_s + dre;
      data_d.im = im_s - dim;
      data_d.z  = data_i.z + atan_c;
    end else begin
      data_d.re = re_s - dre;
      data_d.im = im_s + dim;
      data_d.z  = data_i.z - atan_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* design/tafr_finish.sv */
// Back end: wrap negative angles, round to 1/64 degree, wrap 360 to 0 (2 stages).
// Depends on tafr_pkg.
module tafr_finish import tafr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  rot_t          data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [AW-1:0] angle_o,
  output logic          valid_res_o
);

  logic                 f_valid_q, o_valid_q;
  logic                 f_ready, o_ready;
  logic                 f_zero_q;
  logic signed [ZW-1:0] z_pos_d;
  logic [ZW-1:0]        f_z_q;
  logic [ZW:0]          z_round;
  logic [TW-1:0]        t_raw, t_wrap;
  logic [AW-1:0]        angle_d, angle_q;
  logic                 valid_res_q;

  assign o_ready = !o_valid_q || ready_i;
  assign f_ready = !f_valid_q || o_ready;
  assign ready_o = f_ready;

  // stage F: bring the accumulator into [0, 360)
  assign z_pos_d = data_i.z[ZW-1] ? (data_i.z + DEG360) : data_i.z;

  // stage O: round half up, fold a full turn to zero
  assign z_round = {1'b0, f_z_q} + ROUND_HALF;
  assign t_raw   = z_round[ZW:ZW-TW+1];
  assign t_wrap  = (t_raw >= ANGLE_WRAP) ? (t_raw - ANGLE_WRAP) : t_raw;
  assign angle_d = f_zero_q ? '0 : t_wrap[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (f_ready) f_valid_q <= valid_i;
      if (o_ready) o_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_ready && valid_i) begin
      f_z_q    <= z_pos_d;
      f_zero_q <= data_i.zero;
    end
    if (o_ready && f_valid_q) begin
      angle_q     <= angle_d;
      valid_res_q <= !f_zero_q;
    end
  end

  assign valid_o     = o_valid_q;
  assign angle_o     = angle_q;
  assign valid_res_o = valid_res_q;

endmodule

/* sim/tafr_angle_check.sv */
// Watches the register port and both channels of the tilt angle block.
// Predicts every result word with a CORDIC of its own and compares. Needs tafr_pkg.
module tafr_angle_check import tafr_pkg::*; #(
  parameter int unsigned ANGLE_STEPS = ANGLE_STEPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [DW-1:0]        cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic signed [DW-1:0] sample_x_i,
  input  logic signed [DW-1:0] sample_y_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [AW-1:0]        angle_i,
  input  logic                 valid_res_i,
  input  logic                 done_i,
  output int unsigned          outstanding_o,
  output int unsigned          mismatches_o
);

  // more steps than the table holds are not taken
  localparam int unsigned ROT_STEPS = (ANGLE_STEPS > TABLE_LEN) ? TABLE_LEN : ANGLE_STEPS;
  localparam longint PRESCALE   = 64'sd1 << PRE_SHIFT;
  localparam longint HALF_STEP  = 64'sd32768;
  localparam int unsigned FRAC  = 16;  // accumulator bits below 1/64 degree

  // atan(2^-i) in degrees, 2^22 scale
  localparam longint ATAN_Q22 [TABLE_LEN] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342,
    58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29
  };

  typedef struct packed {
    logic [AW-1:0] angle;
    logic          valid_res;
  } angle_word_t;

  logic signed [DW-1:0] ref_x_q;
  logic signed [DW-1:0] ref_y_q;
  angle_word_t          expected_angles_q[$];
  angle_word_t          head_w;
  logic                 leftover_checked;
  int unsigned          mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // angle of the sample rotated back by the reference, 1/64 degree
  function automatic angle_word_t tilt_angle_of(input logic signed [DW-1:0] sx,
                                                input logic signed [DW-1:0] sy,
                                                input logic signed [DW-1:0] rx,
                                                input logic signed [DW-1:0] ry);
    angle_word_t w;
    longint      re, im, z, dre, dim;
    int          i;
    w = '0;
    if ((sx == 0 && sy == 0) || (rx == 0 && ry == 0)) return w;
    re = (longint'(sx) * longint'(rx) + longint'(sy) * longint'(ry)) * PRESCALE;
    im = (longint'(sy) * longint'(rx) - longint'(sx) * longint'(ry)) * PRESCALE;
    z  = 0;
    // left half-plane: fold over and start from 180 degrees
    if (re < 0) begin
      re = -re;
      im = -im;
      z  = longint'(DEG180);
    end
    for (i = 0; i < ROT_STEPS; i++) begin
      dre = im >>> i;
      dim = re >>> i;
      if (im >= 0) begin
        re += dre;
        im -= dim;
        z  += ATAN_Q22[i];
      end else begin
        re -= dre;
        im += dim;
        z  -= ATAN_Q22[i];
      end
    end
    if (z < 0) z += longint'(DEG360);
    z = (z + HALF_STEP) >>> FRAC;
    // a full turn after rounding reads as zero
    if (z >= longint'(ANGLE_WRAP)) z -= longint'(ANGLE_WRAP);
    w.angle     = z[AW-1:0];
    w.valid_res = 1'b1;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q          <= REF_X_RESET;
      ref_y_q          <= REF_Y_RESET;
      expected_angles_q.delete();
      outstanding_o    <= 0;
      leftover_checked <= 1'b0;
    end else begin
      // reference registers
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_REF_X: ref_x_q <= cfg_data_i;
          REG_REF_Y: ref_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      // result word against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_angles_q.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected: angle=%0d valid_res=%0b",
                                    angle_i, valid_res_i));
        end else begin
          head_w = expected_angles_q.pop_front();
          if (angle_i !== head_w.angle)
            report_mismatch($sformatf("angle %0d, expected %0d", angle_i, head_w.angle));
          if (valid_res_i !== head_w.valid_res)
            report_mismatch($sformatf("valid_res %0b, expected %0b",
                                      valid_res_i, head_w.valid_res));
        end
      end
      // accepted sample word
      if (in_valid_i && !in_stall_i)
        expected_angles_q.push_back(tilt_angle_of(sample_x_i, sample_y_i, ref_x_q, ref_y_q));
      outstanding_o <= expected_angles_q.size();
      // end of run: nothing may still be waiting
      if (done_i && !leftover_checked) begin
        leftover_checked <= 1'b1;
        if (expected_angles_q.size() != 0)
          report_mismatch($sformatf("%0d result words never arrived",
                                    expected_angles_q.size()));
      end
    end
  end

endmodule

/* sim/tb.sv */
// Top of the tilt angle test: clock, reset, sample and register stimulus, verdict.
// Needs tafr_pkg, tilt_angle_from_reference and tafr_angle_check.
module tb;
  import tafr_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [0:0]           cfg_idx_i;
  logic [DW-1:0]        cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [DW-1:0] sample_x_i;
  logic signed [DW-1:0] sample_y_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [AW-1:0]        angle_o;
  logic                 valid_res_o;
  logic                 idle_on;
  logic                 run_done;
  int unsigned          outstanding;
  int unsigned          mismatches;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  tilt_angle_from_reference u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_x_i  (sample_x_i),
    .sample_y_i  (sample_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .angle_o     (angle_o),
    .valid_res_o (valid_res_o)
  );

  tafr_angle_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .sample_x_i    (sample_x_i),
    .sample_y_i    (sample_y_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .angle_i       (angle_o),
    .valid_res_i   (valid_res_o),
    .done_i        (run_done),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  // receiver stalls about a quarter of the time unless idling is off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 25);
    end
  end

  // one sample word; valid stays high afterwards unless a gap follows
  task automatic send_sample(input logic [DW-1:0] x, input logic [DW-1:0] y);
    if (idle_on) begin
      while ($urandom_range(99) < 25) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    sample_x_i <= x;
    sample_y_i <= y;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop sending and wait for every predicted word to come out
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_refs(input logic [DW-1:0] rx, input logic [DW-1:0] ry);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_REF_X;
    cfg_data_i <= rx;
    @(posedge clk_i);
    cfg_idx_i  <= REG_REF_Y;
    cfg_data_i <= ry;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // mix of full range, small, extreme and zero components
  function automatic logic [DW-1:0] rand_component();
    logic [DW-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'hFFFF;
          3:       v = 16'h0001;
          default: v = '0;
        endcase
      end
      1, 2: begin
        v = 16'($urandom_range(16));
        v = v - 16'd8;
      end
      3:       v = '0;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    int unsigned p, k;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_REF_X;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    sample_x_i <= '0;
    sample_y_i <= '0;
    idle_on    <= 1'b1;
    run_done   <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset reference along +x: axes, quadrants, zero sample, near full turn
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h0000);
    send_sample(16'h0000, 16'h7FFF);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h0000, 16'h8000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h7FFF, 16'hFFFF);
    send_sample(16'h0001, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0001, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);

    // zero reference gives angle 0 with valid_res low
    drain_pipe();
    write_refs(16'h0000, 16'h0000);
    send_sample(16'h0064, 16'hFFFB);
    send_sample(16'h7FFF, 16'h7FFF);

    // extreme references
    drain_pipe();
    write_refs(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    drain_pipe();
    write_refs(16'h7FFF, 16'h8000);
    send_sample(16'h0000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h0000, 16'h0000);

    // random phases, each under its own reference; phase 2 runs without idling
    for (p = 0; p < 6; p++) begin
      drain_pipe();
      idle_on <= (p != 2);
      case (p)
        0:       write_refs(16'h8000, 16'h7FFF);
        1:       write_refs(16'h0001, 16'h0000);
        default: write_refs(rand_component(), rand_component());
      endcase
      for (k = 0; k < 115; k++) begin
        // sender waits for the pipeline to empty mid-phase
        if (p == 1 && k == 57) drain_pipe();
        send_sample(rand_component(), rand_component());
      end
    end

    drain_pipe();
    repeat (40) @(posedge clk_i);
    run_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin
    #6000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
